[hw/rtl/spq_pkg.sv]
// Shared codes and control/status structs for the stable priority queue.
// No dependencies.
package spq_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SERVE  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] ST_SERVED = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic       accept;  // input transfer this cycle
		logic [1:0] op;
		logic       scan;    // controller in scan phase
		logic       shift;   // controller in compaction phase
		logic       finish;  // serve complete, load result
	} spq_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_last;
		logic shift_done;
	} spq_sts_t;

endpackage

[hw/rtl/spq_ctrl.sv]
// Controller for the stable priority queue: handshakes and serve sequencing.
// Depends on spq_pkg.
module spq_ctrl import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic [1:0] operation,
	output logic     out_valid,
	input  logic     out_ready,
	output spq_cmd_t cmd,
	input  spq_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_SHIFT = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   acc;
	logic   early;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign acc      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// insert on full and serve on empty answer at once
	assign early = acc && (((operation == OP_INSERT) && sts.full) ||
	                       ((operation == OP_SERVE) && sts.empty));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && (operation == OP_SERVE) && !sts.empty)
					state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_last)
					state_d = S_SHIFT;
			end
			S_SHIFT: begin
				if (sts.shift_done)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.accept = acc;
		cmd.op     = operation;
		cmd.scan   = (state_q == S_SCAN);
		cmd.shift  = (state_q == S_SHIFT);
		cmd.finish = (state_q == S_SHIFT) && sts.shift_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (early || cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result slot is always free while a serve is in flight
	a_busy_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !out_valid_q)
		else $error("result pending during serve");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !sts.empty)
		else $error("scan on empty queue");

	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (out_valid_q && (state_q == S_IDLE)))
		else $error("finished serve gave no result");

endmodule

[hw/rtl/spq_dpath.sv]
// Datapath for the stable priority queue: entry memory, count, stamp,
// scan comparator, compaction pointers and result register. Depends on spq_pkg.
module spq_dpath import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int STAMP_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  spq_cmd_t    cmd,
	output spq_sts_t    sts,
	input  logic [7:0]  severity,
	input  logic [15:0] request_id,
	output logic [15:0] served_id,
	output logic [1:0]  status
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0]            sev;
		logic [15:0]           id;
		logic [STAMP_BITS-1:0] stamp;
	} entry_t;

	entry_t mem [QUEUE_DEPTH];
	entry_t rdata_q;

	logic [CW-1:0]         count_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [CW-1:0]         rd_ptr_q;
	logic [IW-1:0]         rd_idx_q;
	logic                  data_vld_q;
	logic [IW-1:0]         wr_ptr_q;
	logic                  shv_q;

	logic [IW-1:0]         best_idx_q, nb_idx;
	logic [7:0]            best_sev_q, nb_sev;
	logic [15:0]           best_id_q, nb_id;
	logic [STAMP_BITS-1:0] best_stamp_q, nb_stamp;

	logic [15:0] served_id_q;
	logic [1:0]  status_q;

	logic do_insert, rd_more, take;

	assign sts.full  = (count_q == CW'(QUEUE_DEPTH));
	assign sts.empty = (count_q == '0);
	assign do_insert = cmd.accept && (cmd.op == OP_INSERT) && !sts.full;
	assign rd_more   = (rd_ptr_q < count_q);

	assign sts.scan_last  = cmd.scan && data_vld_q && (CW'(rd_idx_q) == count_q - CW'(1));
	assign sts.shift_done = cmd.shift && !shv_q && !rd_more;

	// later entry wins only when strictly ahead: ties keep arrival order
	assign take = (rd_idx_q == '0) || (rdata_q.sev > best_sev_q) ||
	              ((rdata_q.sev == best_sev_q) && (rdata_q.stamp < best_stamp_q));

	always_comb begin
		nb_idx   = best_idx_q;
		nb_sev   = best_sev_q;
		nb_id    = best_id_q;
		nb_stamp = best_stamp_q;
		if (cmd.scan && data_vld_q && take) begin
			nb_idx   = rd_idx_q;
			nb_sev   = rdata_q.sev;
			nb_id    = rdata_q.id;
			nb_stamp = rdata_q.stamp;
		end
	end

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_insert)
			mem[count_q[IW-1:0]] <= '{sev: severity, id: request_id, stamp: stamp_q};
		else if (cmd.shift && shv_q)
			mem[wr_ptr_q] <= rdata_q;
		if ((cmd.scan || cmd.shift) && rd_more)
			rdata_q <= mem[rd_ptr_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		best_idx_q   <= nb_idx;
		best_sev_q   <= nb_sev;
		best_id_q    <= nb_id;
		best_stamp_q <= nb_stamp;
		if (cmd.finish) begin
			served_id_q <= best_id_q;
			status_q    <= ST_SERVED;
		end else if (cmd.accept && (cmd.op == OP_SERVE) && sts.empty) begin
			served_id_q <= '0;
			status_q    <= ST_EMPTY;
		end else if (cmd.accept && (cmd.op == OP_INSERT) && sts.full) begin
			served_id_q <= '0;
			status_q    <= ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			stamp_q    <= '0;
			rd_ptr_q   <= '0;
			rd_idx_q   <= '0;
			data_vld_q <= 1'b0;
			wr_ptr_q   <= '0;
			shv_q      <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (cmd.op == OP_CLEAR) begin
					count_q <= '0;
					stamp_q <= '0;
				end else if ((cmd.op == OP_INSERT) || (cmd.op == OP_SERVE)) begin
					if (stamp_q != '1)
						stamp_q <= stamp_q + STAMP_BITS'(1);
					if (do_insert)
						count_q <= count_q + CW'(1);
				end
				rd_ptr_q   <= '0;
				data_vld_q <= 1'b0;
			end else if (cmd.scan) begin
				if (sts.scan_last) begin
					rd_ptr_q   <= CW'(nb_idx) + CW'(1);
					wr_ptr_q   <= nb_idx;
					shv_q      <= 1'b0;
					data_vld_q <= 1'b0;
				end else begin
					data_vld_q <= rd_more;
					if (rd_more) begin
						rd_idx_q <= rd_ptr_q[IW-1:0];
						rd_ptr_q <= rd_ptr_q + CW'(1);
					end
				end
			end else if (cmd.shift) begin
				shv_q <= rd_more;
				if (rd_more)
					rd_ptr_q <= rd_ptr_q + CW'(1);
				if (shv_q)
					wr_ptr_q <= wr_ptr_q + IW'(1);
				if (cmd.finish)
					count_q <= count_q - CW'(1);
			end
		end
	end

	assign served_id = served_id_q;
	assign status    = status_q;

endmodule

[hw/rtl/stable_priority_queue.sv]
// Top level of the stable priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl, spq_dpath.
//
//  channel | signals                                  | transfer when
//  in      | in_valid in_ready operation severity request_id | in_valid & in_ready
//  out     | out_valid out_ready served_id status     | out_valid & out_ready
//
// Insert and clear complete as they are accepted; insert on full and serve
// on empty answer without a scan. A serve scans the n stored entries through
// the single memory read port and then compacts the entries above the winner,
// one per cycle.
// Reset is asynchronous; the entry memory needs no clearing pass.
// Input is held off while a serve runs or a result waits that is not taken.
module stable_priority_queue import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int STAMP_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  severity,
	input  logic [15:0] request_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] served_id,
	output logic [1:0]  status
);

	spq_cmd_t cmd;
	spq_sts_t sts;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	spq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.STAMP_BITS  (STAMP_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.severity   (severity),
		.request_id (request_id),
		.served_id  (served_id),
		.status     (status)
	);

endmodule
